// ----- src/annexb_to_avcc_video_tag_macros.svh -----
// Assertion helpers used by the checker module avtag_chk.
`ifndef ANNEXB_TO_AVCC_VIDEO_TAG_MACROS_SVH
`define ANNEXB_TO_AVCC_VIDEO_TAG_MACROS_SVH

// Check on every clock edge outside reset.
`define AVT_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Check on every clock edge, reset included.
`define AVT_CHECK_ALL(name, expr, msg) \
  name: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ----- src/avtag_pkg.sv -----
package avtag_pkg;

  // Internal offset and count width; covers body sizes up to 2^24 bytes.
  localparam int unsigned OFS_W = 25;

  localparam logic [7:0] HDR_KEY        = 8'h17;
  localparam logic [7:0] HDR_INTER      = 8'h27;
  localparam logic [7:0] AVC_NALU       = 8'h01;
  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam int unsigned BODY_START    = 5;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_HDR  = 2'd2,
    KIND_END  = 2'd3
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_NAL   = 2'd1,
    ST_OVERFLOW = 2'd2
  } frame_status_t;

  // Everything one input byte produces, in emission order:
  // header, first data run, first length word, zero run, second length word, frame end.
  typedef struct packed {
    logic             hdr_en;
    logic             key;
    logic [2:0]       d1_k;
    logic [1:0]       d1_zix;
    logic [7:0]       data_byte;
    logic [OFS_W-1:0] d1_off;
    logic             l1_en;
    logic [OFS_W-1:0] l1_off;
    logic [OFS_W-1:0] l1_val;
    logic [1:0]       d2_k;
    logic [OFS_W-1:0] d2_off;
    logic             l2_en;
    logic [OFS_W-1:0] l2_off;
    logic [OFS_W-1:0] l2_val;
    logic             end_en;
    logic [OFS_W-1:0] end_size;
    frame_status_t    status;
    logic [31:0]      stamp;
  } cmd_t;

endpackage

// ----- src/avtag_front.sv -----
module avtag_front #(
  parameter int unsigned MAX_BODY_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_frame_last,
  input  logic              in_keyframe,
  input  logic [31:0]       in_timestamp,
  output logic              cmd_push,
  output avtag_pkg::cmd_t   cmd,
  input  logic              cmd_full
);

  localparam int unsigned W = avtag_pkg::OFS_W;
  localparam logic [W-1:0] MAX_V     = W'(MAX_BODY_BYTES);
  localparam logic [W-1:0] START_OFS = W'(avtag_pkg::BODY_START);
  localparam logic [W-1:0] LEN_SLOT  = W'(4);

  logic [1:0]   pz_r, pz_nxt;
  logic         in_nal_r, in_nal_nxt;
  logic         stopped_r, stopped_nxt;
  logic         at_start_r, at_start_nxt;
  logic         any_nal_r, any_nal_nxt;
  logic         ovf_r, ovf_nxt;
  logic [W-1:0] slot_r, slot_nxt;
  logic [W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] wo_r, wo_nxt;
  logic [31:0]  stamp_r, stamp_nxt;
  logic         accept;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [2:0]   n;
    logic         run;
    logic         sc;
    logic [W-1:0] room;
    logic [2:0]   k;
    logic [1:0]   m;
    logic [1:0]   k2;

    pz_nxt       = pz_r;
    in_nal_nxt   = in_nal_r;
    stopped_nxt  = stopped_r;
    at_start_nxt = at_start_r;
    any_nal_nxt  = any_nal_r;
    ovf_nxt      = ovf_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    wo_nxt       = wo_r;
    stamp_nxt    = stamp_r;
    cmd          = '0;
    n            = '0;
    run          = 1'b0;
    sc           = 1'b0;
    room         = '0;
    k            = '0;
    m            = '0;
    k2           = '0;

    // first byte of the frame: header and timestamp
    if (at_start_r) begin
      cmd.hdr_en = 1'b1;
      cmd.key    = in_keyframe;
      stamp_nxt  = in_timestamp;
      wo_nxt     = START_OFS;
    end

    if (!stopped_nxt) begin
      cmd.data_byte = in_data_byte;
      cmd.d1_zix    = pz_nxt;
      if (in_data_byte == 8'h00) begin
        if (pz_nxt != 2'd3) begin
          pz_nxt = pz_nxt + 2'd1;
        end else begin
          n   = 3'd1;
          run = 1'b1;
        end
      end else if (in_data_byte == avtag_pkg::START_CODE_END && pz_nxt >= 2'd2) begin
        pz_nxt = '0;
        sc     = 1'b1;
      end else begin
        n      = {1'b0, pz_nxt} + 3'd1;
        pz_nxt = '0;
        run    = 1'b1;
      end

      // held zeros and the byte itself, clipped at the body limit
      if (run && in_nal_nxt) begin
        room       = MAX_V - wo_nxt;
        k          = (room < W'(n)) ? room[2:0] : n;
        cmd.d1_k   = k;
        cmd.d1_off = wo_nxt;
        wo_nxt     = wo_nxt + W'(k);
        cnt_nxt    = cnt_nxt + W'(k);
        if (room < W'(n)) begin
          ovf_nxt     = 1'b1;
          stopped_nxt = 1'b1;
          sc          = 1'b1;
        end
      end

      // close the open NAL (start code or overflow)
      if (sc && in_nal_nxt) begin
        in_nal_nxt = 1'b0;
        if (cnt_nxt == '0) begin
          wo_nxt      = slot_nxt;
          stopped_nxt = 1'b1;
        end else begin
          cmd.l1_en   = 1'b1;
          cmd.l1_off  = slot_nxt;
          cmd.l1_val  = cnt_nxt;
          any_nal_nxt = 1'b1;
        end
        cnt_nxt = '0;
      end

      // open the next NAL and reserve its length word
      if (sc && !stopped_nxt) begin
        room = MAX_V - wo_nxt;
        if (room < LEN_SLOT) begin
          ovf_nxt     = 1'b1;
          stopped_nxt = 1'b1;
        end else begin
          slot_nxt   = wo_nxt;
          wo_nxt     = wo_nxt + LEN_SLOT;
          in_nal_nxt = 1'b1;
          cnt_nxt    = '0;
        end
      end
    end

    if (in_frame_last) begin
      m      = pz_nxt;
      pz_nxt = '0;
      if (in_nal_nxt && !stopped_nxt && m != 2'd0) begin
        room       = MAX_V - wo_nxt;
        k2         = (room < W'(m)) ? room[1:0] : m;
        cmd.d2_k   = k2;
        cmd.d2_off = wo_nxt;
        wo_nxt     = wo_nxt + W'(k2);
        cnt_nxt    = cnt_nxt + W'(k2);
        if (room < W'(m)) begin
          ovf_nxt     = 1'b1;
          stopped_nxt = 1'b1;
        end
      end
      if (in_nal_nxt) begin
        in_nal_nxt = 1'b0;
        if (cnt_nxt == '0) begin
          wo_nxt      = slot_nxt;
          stopped_nxt = 1'b1;
        end else begin
          cmd.l2_en   = 1'b1;
          cmd.l2_off  = slot_nxt;
          cmd.l2_val  = cnt_nxt;
          any_nal_nxt = 1'b1;
        end
      end
      cmd.end_en   = 1'b1;
      cmd.end_size = wo_nxt;
      cmd.stamp    = stamp_nxt;
      if (ovf_nxt) begin
        cmd.status = avtag_pkg::ST_OVERFLOW;
      end else if (!any_nal_nxt) begin
        cmd.status = avtag_pkg::ST_NO_NAL;
      end else begin
        cmd.status = avtag_pkg::ST_OK;
      end
      // back to a fresh frame
      in_nal_nxt   = 1'b0;
      stopped_nxt  = 1'b0;
      at_start_nxt = 1'b1;
      any_nal_nxt  = 1'b0;
      ovf_nxt      = 1'b0;
      slot_nxt     = '0;
      cnt_nxt      = '0;
      wo_nxt       = START_OFS;
    end else begin
      at_start_nxt = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.hdr_en || cmd.d1_k != 3'd0 || cmd.l1_en ||
                               cmd.d2_k != 2'd0 || cmd.l2_en || cmd.end_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pz_r       <= '0;
      in_nal_r   <= 1'b0;
      stopped_r  <= 1'b0;
      at_start_r <= 1'b1;
      any_nal_r  <= 1'b0;
      ovf_r      <= 1'b0;
      slot_r     <= '0;
      cnt_r      <= '0;
      wo_r       <= START_OFS;
      stamp_r    <= '0;
    end else if (accept) begin
      pz_r       <= pz_nxt;
      in_nal_r   <= in_nal_nxt;
      stopped_r  <= stopped_nxt;
      at_start_r <= at_start_nxt;
      any_nal_r  <= any_nal_nxt;
      ovf_r      <= ovf_nxt;
      slot_r     <= slot_nxt;
      cnt_r      <= cnt_nxt;
      wo_r       <= wo_nxt;
      stamp_r    <= stamp_nxt;
    end
  end

endmodule

// ----- src/avtag_cmdq.sv -----
module avtag_cmdq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  avtag_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output avtag_pkg::cmd_t head,
  output logic            head_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  avtag_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ----- src/avtag_back.sv -----
module avtag_back (
  input  logic            clk,
  input  logic            rst_n,
  input  avtag_pkg::cmd_t head,
  input  logic            head_valid,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_item_kind,
  output logic [19:0]     out_body_offset,
  output logic [39:0]     out_item_value,
  output logic [1:0]      out_frame_status,
  output logic [31:0]     out_frame_stamp,
  output logic            out_last_of_run
);

  localparam int unsigned W = avtag_pkg::OFS_W;

  logic        hdr_done_r, hdr_done_nxt;
  logic [2:0]  d1_idx_r, d1_idx_nxt;
  logic        l1_done_r, l1_done_nxt;
  logic [1:0]  d2_idx_r, d2_idx_nxt;
  logic        l2_done_r, l2_done_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [19:0] ofs_r;
  logic [39:0] val_r;
  logic [1:0]  st_r;
  logic [31:0] stamp_r;
  logic        last_r;

  avtag_pkg::item_kind_t      kind;
  logic [W-1:0]               ofs;
  logic [39:0]                val;
  avtag_pkg::frame_status_t   st;
  logic [31:0]                stamp;
  logic                       is_last;
  logic                       load;

  logic after_hdr, after_d1, after_l1, after_d2, after_l2;

  assign after_l2  = head.end_en;
  assign after_d2  = head.l2_en || after_l2;
  assign after_l1  = (head.d2_k != 2'd0) || after_d2;
  assign after_d1  = head.l1_en || after_l1;
  assign after_hdr = (head.d1_k != 3'd0) || after_d1;

  // pick the next item of the head transaction in emission order
  always_comb begin
    hdr_done_nxt = hdr_done_r;
    d1_idx_nxt   = d1_idx_r;
    l1_done_nxt  = l1_done_r;
    d2_idx_nxt   = d2_idx_r;
    l2_done_nxt  = l2_done_r;
    kind         = avtag_pkg::KIND_END;
    ofs          = '0;
    val          = '0;
    st           = avtag_pkg::ST_OK;
    stamp        = '0;
    is_last      = 1'b1;
    priority if (head.hdr_en && !hdr_done_r) begin
      kind         = avtag_pkg::KIND_HDR;
      val          = {(head.key ? avtag_pkg::HDR_KEY : avtag_pkg::HDR_INTER),
                      avtag_pkg::AVC_NALU, 24'h0};
      is_last      = !after_hdr;
      hdr_done_nxt = 1'b1;
    end else if (d1_idx_r < head.d1_k) begin
      kind       = avtag_pkg::KIND_DATA;
      ofs        = head.d1_off + W'(d1_idx_r);
      val        = (d1_idx_r == {1'b0, head.d1_zix}) ? 40'(head.data_byte) : '0;
      is_last    = (d1_idx_r == head.d1_k - 3'd1) && !after_d1;
      d1_idx_nxt = d1_idx_r + 3'd1;
    end else if (head.l1_en && !l1_done_r) begin
      kind        = avtag_pkg::KIND_LEN;
      ofs         = head.l1_off;
      val         = 40'(head.l1_val);
      is_last     = !after_l1;
      l1_done_nxt = 1'b1;
    end else if (d2_idx_r < head.d2_k) begin
      kind       = avtag_pkg::KIND_DATA;
      ofs        = head.d2_off + W'(d2_idx_r);
      is_last    = (d2_idx_r == head.d2_k - 2'd1) && !after_d2;
      d2_idx_nxt = d2_idx_r + 2'd1;
    end else if (head.l2_en && !l2_done_r) begin
      kind        = avtag_pkg::KIND_LEN;
      ofs         = head.l2_off;
      val         = 40'(head.l2_val);
      is_last     = !after_l2;
      l2_done_nxt = 1'b1;
    end else begin
      val   = 40'(head.end_size);
      st    = head.status;
      stamp = head.stamp;
    end
  end

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign cmd_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind;
      ofs_r   <= ofs[19:0];
      val_r   <= val;
      st_r    <= st;
      stamp_r <= stamp;
      last_r  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hdr_done_r  <= 1'b0;
      d1_idx_r    <= '0;
      l1_done_r   <= 1'b0;
      d2_idx_r    <= '0;
      l2_done_r   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (is_last) begin
          hdr_done_r <= 1'b0;
          d1_idx_r   <= '0;
          l1_done_r  <= 1'b0;
          d2_idx_r   <= '0;
          l2_done_r  <= 1'b0;
        end else begin
          hdr_done_r <= hdr_done_nxt;
          d1_idx_r   <= d1_idx_nxt;
          l1_done_r  <= l1_done_nxt;
          d2_idx_r   <= d2_idx_nxt;
          l2_done_r  <= l2_done_nxt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_body_offset  = ofs_r;
  assign out_item_value   = val_r;
  assign out_frame_status = st_r;
  assign out_frame_stamp  = stamp_r;
  assign out_last_of_run  = last_r;

endmodule

// ----- src/annexb_to_avcc_video_tag.sv -----
// Annex-B H.264 frame to FLV video tag body, as a stream of placed writes.
// Input channel (in_*): one frame byte per transaction; in_frame_last marks the
//   final byte, in_keyframe and in_timestamp are sampled on the first byte.
// Output channel (out_*): one write per transaction: tag header at offset 0,
//   NAL payload bytes, patched 4-byte NAL length words, and a frame-end
//   transaction with the body size, status and latched timestamp.
//   out_last_of_run flags the final write caused by one input byte.
// Timing: the first write of a byte is queued at the accepting edge, then loaded
//   from the queue head into the output register once that register is free.
// Throughput: one input byte per cycle while the command queue has room, and
//   one write per cycle on the output while the receiver is ready; a byte that
//   causes several writes (header, flushed zeros, length word, frame end; up to
//   six) holds the back end until all are out, and the queue absorbs the difference.
// Reset: synchronous, active low; drops queued work and starts a new frame.
// Receiver stall: the output register holds its write; the back end stops,
//   the queue fills, and in_ready drops once CMDQ_DEPTH transactions wait.
module annexb_to_avcc_video_tag #(
  parameter int unsigned MAX_BODY_BYTES = 1048576,
  parameter int unsigned CMDQ_DEPTH     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_last,
  input  logic        in_keyframe,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [19:0] out_body_offset,
  output logic [39:0] out_item_value,
  output logic [1:0]  out_frame_status,
  output logic [31:0] out_frame_stamp,
  output logic        out_last_of_run
);

  avtag_pkg::cmd_t push_cmd;
  avtag_pkg::cmd_t head_cmd;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            head_valid;

  // Front: start-code detection, NAL bookkeeping and body offsets per byte.
  avtag_front #(
    .MAX_BODY_BYTES(MAX_BODY_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_last(in_frame_last),
    .in_keyframe  (in_keyframe),
    .in_timestamp (in_timestamp),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd),
    .cmd_full     (cmd_full)
  );

  // Short queue that lets the front run ahead of multi-write transactions.
  avtag_cmdq #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (head_cmd),
    .head_valid(head_valid)
  );

  // Back: expand each queued command into writes, one per cycle while out_ready allows.
  avtag_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_cmd),
    .head_valid      (head_valid),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_body_offset (out_body_offset),
    .out_item_value  (out_item_value),
    .out_frame_status(out_frame_status),
    .out_frame_stamp (out_frame_stamp),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- src/avtag_chk.sv -----
`include "annexb_to_avcc_video_tag_macros.svh"

module avtag_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_frame_last,
  input logic        in_keyframe,
  input logic [31:0] in_timestamp,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_item_kind,
  input logic [19:0] out_body_offset,
  input logic [39:0] out_item_value,
  input logic [1:0]  out_frame_status,
  input logic [31:0] out_frame_stamp,
  input logic        out_last_of_run
);

  // a stalled write holds
  `AVT_CHECK(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_item_value) && $stable(out_body_offset) && $stable(out_item_kind)), "stalled output changed")

  // reset empties the output register
  `AVT_CHECK_ALL(a_rst_idle, (!rst_n |=> !out_valid), "output valid after reset")

  // status and stamp only on the frame-end write
  `AVT_CHECK(a_status_end, (out_valid && out_item_kind != avtag_pkg::KIND_END |-> out_frame_status == 2'd0 && out_frame_stamp == 32'd0), "status outside frame end")

  // header goes to offset 0 with a valid frame type byte
  `AVT_CHECK(a_hdr_form, (out_valid && out_item_kind == avtag_pkg::KIND_HDR |-> out_body_offset == 20'd0 && (out_item_value[39:32] == avtag_pkg::HDR_KEY || out_item_value[39:32] == avtag_pkg::HDR_INTER) && out_item_value[31:24] == avtag_pkg::AVC_NALU && out_item_value[23:0] == 24'd0), "malformed tag header")

  // frame end closes the run of its byte
  `AVT_CHECK(a_end_last, (out_valid && out_item_kind == avtag_pkg::KIND_END |-> out_last_of_run), "frame end not last of run")

endmodule

bind annexb_to_avcc_video_tag avtag_chk u_avtag_chk (.*);
